// ===== src/ascending_integer_sorter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ascending integer sorter
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASCENDING_INTEGER_SORTER_ASSERT_SVH
`define ASCENDING_INTEGER_SORTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AIS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ais_pkg.sv =====
// ----------------------------------------------------------------------------
// Ascending integer sorter package
// Sizes, the element type, the controller states and the cell control group.
// ----------------------------------------------------------------------------
package ais_pkg;

    localparam int DEPTH   = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [COUNT_W-1:0]       count_t;

    typedef enum logic
    {
        ST_FILL,
        ST_DRAIN
    } state_t;

    typedef struct packed
    {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== src/ais_cell.sv =====
// ----------------------------------------------------------------------------
// Sorter cell
// Holds one element; inserts in order while filling and shifts toward the
// head while draining.
// ----------------------------------------------------------------------------
module ais_cell
(
    input  logic               clk,
    input  ais_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  ais_pkg::data_t     in_value,
    input  ais_pkg::data_t     left_value,
    input  logic               left_lt,
    input  ais_pkg::data_t     right_value,
    output ais_pkg::data_t     value,
    output logic               lt
);
    import ais_pkg::*;

    data_t value_reg;
    data_t value_next;

    // An empty cell behaves as if it held a value above every input.
    assign lt    = !occupied || (in_value < value_reg);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = right_value;
        end
        else if (ctrl.load && lt)
        begin
            // Either the new element lands here, or the left neighbor moves in.
            value_next = left_lt ? left_value : in_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== src/ascending_integer_sorter.sv =====
// ----------------------------------------------------------------------------
// Ascending integer sorter
// Collects a batch of signed words in a row of insertion cells and emits it
// in ascending order when the last beat of the batch arrives.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                | Payload
//  --------+--------------------------+-------------------------------------
//  input   | item_valid / item_stall  | value, last
//  result  | res_valid / res_stall    | sorted_value, final_res, dropped
//
// Each input beat is inserted on acceptance: every cell compares the new word
// with its own element and the row shifts right past the insertion point.
// After the last beat, the batch drains from the head cell at one beat per
// cycle whenever the output register is free to take a result.
// While draining, item_stall is high; a new batch may start loading as soon
// as the final result sits in the output register.
// Reset clears the element count, the overflow flag, the controller and the
// output valid; the cell contents are not reset.
// ----------------------------------------------------------------------------
module ascending_integer_sorter
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  ais_pkg::data_t value,
    input  logic           last,
    output logic           res_valid,
    input  logic           res_stall,
    output ais_pkg::data_t sorted_value,
    output logic           final_res,
    output logic           dropped
);
    import ais_pkg::*;

`include "ascending_integer_sorter_assert.svh"

    state_t     state_reg;
    state_t     state_next;
    count_t     count_reg;
    count_t     count_next;
    logic       drop_reg;
    logic       drop_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    data_t      res_value_reg;
    data_t      res_value_next;
    logic       res_final_reg;
    logic       res_final_next;
    logic       res_drop_reg;
    logic       res_drop_next;

    logic       in_accept;
    logic       insert;
    logic       slot_free;
    logic       shift;
    cell_ctrl_t cell_ctrl;

    data_t      cell_value [DEPTH];
    logic       cell_lt    [DEPTH];
    logic       cell_occ   [DEPTH];

    // ------------------------------------------------------------------
    // Cell row. Cell 0 is the head and always holds the smallest element.
    // ------------------------------------------------------------------
    assign cell_ctrl.load  = insert;
    assign cell_ctrl.shift = shift;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            data_t left_v;
            logic  left_l;
            data_t right_v;

            assign cell_occ[gi] = (COUNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_v = value;
                assign left_l = 1'b0;
            end
            else
            begin : g_body
                assign left_v = cell_value[gi-1];
                assign left_l = cell_lt[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_v = cell_value[gi];
            end
            else
            begin : g_inner
                assign right_v = cell_value[gi+1];
            end

            ais_cell u_cell
            (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .occupied    (cell_occ[gi]),
                .in_value    (value),
                .left_value  (left_v),
                .left_lt     (left_l),
                .right_value (right_v),
                .value       (cell_value[gi]),
                .lt          (cell_lt[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Controller outputs.
    // ------------------------------------------------------------------
    assign slot_free = !res_valid_reg || !res_stall;
    assign in_accept = item_valid && !item_stall;
    assign insert    = in_accept && (count_reg < COUNT_W'(DEPTH));

    always_comb
    begin
        item_stall = 1'b0;
        shift      = 1'b0;
        case (state_reg)
            ST_FILL:
            begin
                item_stall = 1'b0;
                shift      = 1'b0;
            end
            ST_DRAIN:
            begin
                item_stall = 1'b1;
                shift      = slot_free;
            end
            default:
            begin
                item_stall = 1'b1;
                shift      = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Controller next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (in_accept && last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (shift && (count_reg == COUNT_W'(1)))
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Element count, overflow flag and the output register. The count
    // doubles as the number of results still to drain.
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next     = count_reg;
        drop_next      = drop_reg;
        res_valid_next = res_valid_reg;
        res_value_next = res_value_reg;
        res_final_next = res_final_reg;
        res_drop_next  = res_drop_reg;

        if (insert)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (in_accept)
        begin
            // The store is full: the beat is lost, but a last beat still closes.
            drop_next = 1'b1;
        end

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        if (shift)
        begin
            res_valid_next = 1'b1;
            res_value_next = cell_value[0];
            res_final_next = (count_reg == COUNT_W'(1));
            res_drop_next  = drop_reg;
            count_next     = count_reg - COUNT_W'(1);
            if (count_reg == COUNT_W'(1))
            begin
                drop_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_value_reg <= res_value_next;
        res_final_reg <= res_final_next;
        res_drop_reg  <= res_drop_next;
    end

    assign res_valid    = res_valid_reg;
    assign sorted_value = res_value_reg;
    assign final_res    = res_final_reg;
    assign dropped      = res_drop_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `AIS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= COUNT_W'(DEPTH), "count above depth")
    `AIS_ASSERT_SAME(a_drain_nonempty, state_reg == ST_DRAIN, count_reg != '0, "drain with no elements")
    `AIS_ASSERT_SAME(a_head_sorted, shift && (count_reg > COUNT_W'(1)), !(cell_value[1] < cell_value[0]), "head not smallest")
    `AIS_ASSERT_NEXT(a_batch_closed, shift && (count_reg == COUNT_W'(1)), (state_reg == ST_FILL) && !drop_reg && res_final_reg, "batch not closed after final")

endmodule
